FILE: rtl/okrt_pkg.sv
// ----------------------------------------------------------------------------
// okrt_pkg
// Types and codes shared by the ordered keyed record table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package okrt_pkg;

    localparam int KEY_W    = 24;
    localparam int SAL_W    = 24;
    localparam int DEP_W    = 16;
    localparam int ACT_W    = 3;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = 6;

    localparam logic [ACT_W-1:0] ACT_LOAD   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_BADPOS  = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SAL_W-1:0] sal;
        logic [DEP_W-1:0] dep;
    } rec_t;

    typedef struct packed {
        logic load;
        logic upd;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/okrt_cell.sv
// ----------------------------------------------------------------------------
// okrt_cell
// One table slot: holds a record, compares its key, loads, updates or takes
// the record of its right-hand neighbor when the table closes a gap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okrt_cell
    import okrt_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire rec_t             new_rec,
    input  wire rec_t             neighbor_rec,
    input  wire logic             valid,
    input  wire logic [KEY_W-1:0] cmp_key,
    output rec_t                  rec,
    output logic                  match
);

    rec_t rec_reg;
    rec_t rec_next;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.shift)
        begin
            rec_next = neighbor_rec;
        end
        else if (ctrl.load)
        begin
            rec_next = new_rec;
        end
        else if (ctrl.upd)
        begin
            rec_next.sal = new_rec.sal;
            rec_next.dep = new_rec.dep;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec   = rec_reg;
    assign match = valid && (rec_reg.key == cmp_key);

endmodule

`default_nettype wire

FILE: rtl/ordered_keyed_record_table.sv
// ----------------------------------------------------------------------------
// ordered_keyed_record_table
// Insertion-ordered record table built as a row of slot cells.
//
// Input channel: in_valid / in_stall with action, key_id, salary_value,
// department_value and position. Output channel: out_valid / out_stall with
// status, entry_key, entry_salary, entry_department and entry_count.
// Each transaction yields exactly one result transaction.
// On acceptance every cell compares its key against key_id at once and the
// match vector is registered. Once the output register is free, the commit
// step resolves the first match and commits load, update, delete (cells
// shift left by one past the match) or read into the output register.
// out_valid is registered from the commit. A new transaction is not taken
// until the current one has committed.
// A result held by out_stall stays in the output register; the block still
// takes the next transaction, which then waits in its commit cycle until
// the output register frees.
// Reset empties the table and clears the key counter; slot contents are
// not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_keyed_record_table
    import okrt_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [ACT_W-1:0]   action,
    input  wire logic [KEY_W-1:0]   key_id,
    input  wire logic [SAL_W-1:0]   salary_value,
    input  wire logic [DEP_W-1:0]   department_value,
    input  wire logic [POS_W-1:0]   position,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [STAT_W-1:0]       status,
    output logic [KEY_W-1:0]        entry_key,
    output logic [SAL_W-1:0]        entry_salary,
    output logic [DEP_W-1:0]        entry_department,
    output logic [COUNT_W-1:0]      entry_count
);

    localparam int TW = $clog2(CAPACITY + 1);
    localparam int PW = (TW > COUNT_W) ? TW : COUNT_W;

    logic                   busy_reg, busy_next;
    logic [TW-1:0]          total_reg, total_next;
    logic [KEY_W-1:0]       last_key_reg, last_key_next;
    logic [ACT_W-1:0]       action_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [SAL_W-1:0]       sal_reg;
    logic [DEP_W-1:0]       dep_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [CAPACITY-1:0]    match_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]      status_reg, status_next;
    logic [KEY_W-1:0]       okey_reg, okey_next;
    logic [SAL_W-1:0]       osal_reg, osal_next;
    logic [DEP_W-1:0]       odep_reg, odep_next;

    logic                   accept;
    logic                   out_free;
    logic                   commit;
    logic [CAPACITY-1:0]    match;
    logic [CAPACITY-1:0]    cell_valid;
    logic [CAPACITY-1:0]    first_hit;
    logic [CAPACITY-1:0]    past_hit;
    logic [CAPACITY-1:0]    at_total;
    logic [CAPACITY-1:0]    at_pos;
    cell_ctrl_t             ctrl [CAPACITY];
    rec_t                   rec  [CAPACITY];
    rec_t                   new_rec;
    rec_t                   read_rec;
    logic                   full;
    logic                   found;
    logic [PW-1:0]          total_ext;
    logic [PW-1:0]          pos_ext;
    logic [TW-1:0]          total_inc;
    logic [KEY_W-1:0]       key_inc;
    logic                   do_load, do_upd, do_del;

    assign accept   = in_valid && !in_stall;
    assign in_stall = busy_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = busy_reg && out_free;

    assign total_ext = PW'(total_reg);
    assign pos_ext   = PW'(pos_reg);
    assign total_inc = total_reg + 1'b1;
    assign key_inc   = last_key_reg + 1'b1;
    assign full      = (total_ext >= PW'(CAPACITY));
    assign found     = |match_reg;
    assign first_hit = match_reg & (~match_reg + 1'b1);
    assign past_hit  = ~((match_reg - 1'b1) & ~match_reg);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            assign cell_valid[gi] = (PW'(gi) < total_ext);
            assign at_total[gi]   = (PW'(gi) == total_ext);
            assign at_pos[gi]     = (PW'(gi) == pos_ext);

            assign ctrl[gi].load  = do_load && at_total[gi];
            assign ctrl[gi].upd   = do_upd && first_hit[gi];
            assign ctrl[gi].shift = do_del && past_hit[gi];

            okrt_cell u_cell (
                .clk          (clk),
                .ctrl         (ctrl[gi]),
                .new_rec      (new_rec),
                .neighbor_rec ((gi == CAPACITY - 1) ? rec[gi] : rec[(gi + 1) % CAPACITY]),
                .valid        (cell_valid[gi]),
                .cmp_key      (key_id),
                .rec          (rec[gi]),
                .match        (match[gi])
            );
        end
    endgenerate

    always_comb
    begin
        read_rec = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (at_pos[i])
            begin
                read_rec = read_rec | rec[i];
            end
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        total_next     = total_reg;
        last_key_next  = last_key_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        okey_next      = okey_reg;
        osal_next      = osal_reg;
        odep_next      = odep_reg;
        do_load        = 1'b0;
        do_upd         = 1'b0;
        do_del         = 1'b0;
        new_rec.key    = key_reg;
        new_rec.sal    = sal_reg;
        new_rec.dep    = dep_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end

        if (commit)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            okey_next      = '0;
            osal_next      = '0;
            odep_next      = '0;
            case (action_reg)
                ACT_LOAD:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        do_load       = 1'b1;
                        total_next    = total_inc;
                        last_key_next = KEY_W'(total_inc);
                    end
                end
                ACT_ADD:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        do_load       = 1'b1;
                        new_rec.key   = key_inc;
                        total_next    = total_inc;
                        last_key_next = key_inc;
                        okey_next     = key_inc;
                    end
                end
                ACT_UPDATE:
                begin
                    if (!found)
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else
                    begin
                        do_upd = 1'b1;
                    end
                end
                ACT_DELETE:
                begin
                    if (total_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (!found)
                    begin
                        status_next = ST_UNKNOWN;
                    end
                    else
                    begin
                        do_del     = 1'b1;
                        total_next = total_reg - 1'b1;
                    end
                end
                ACT_READ:
                begin
                    if (pos_ext >= total_ext)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        okey_next = read_rec.key;
                        osal_next = read_rec.sal;
                        odep_next = read_rec.dep;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            total_reg     <= '0;
            last_key_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            total_reg     <= total_next;
            last_key_reg  <= last_key_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            key_reg    <= key_id;
            sal_reg    <= salary_value;
            dep_reg    <= department_value;
            pos_reg    <= position;
            match_reg  <= match;
        end
        status_reg <= status_next;
        okey_reg   <= okey_next;
        osal_reg   <= osal_next;
        odep_reg   <= odep_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign entry_key        = okey_reg;
    assign entry_salary     = osal_reg;
    assign entry_department = odep_reg;

    logic [PW-1:0] count_ext_reg;

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            count_ext_reg <= PW'(total_next);
        end
    end

    assign entry_count = count_ext_reg[COUNT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/okrt_checker.sv
// ----------------------------------------------------------------------------
// okrt_checker
// Port-level checks for the ordered keyed record table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okrt_checker
    import okrt_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [STAT_W-1:0]  status,
    input  wire logic [KEY_W-1:0]   entry_key,
    input  wire logic [SAL_W-1:0]   entry_salary,
    input  wire logic [DEP_W-1:0]   entry_department,
    input  wire logic [COUNT_W-1:0] entry_count
);

    localparam int CAP_LOW = CAPACITY % 64;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second transaction accepted while one is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == COUNT_W'(CAP_LOW))
        else $error("table full reported below capacity");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> entry_count == '0)
        else $error("table empty reported with records present");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |->
            (entry_key == '0) && (entry_salary == '0) && (entry_department == '0))
        else $error("record fields nonzero on error");

endmodule

bind ordered_keyed_record_table okrt_checker #(.CAPACITY(CAPACITY)) u_okrt_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .entry_key        (entry_key),
    .entry_salary     (entry_salary),
    .entry_department (entry_department),
    .entry_count      (entry_count)
);

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ordered_keyed_record_table. A directed opening
// covers the empty table, the extremes of every field, duplicate keys and the
// unused action codes; random transactions then grow, shrink and mix the
// table so that full, empty, unknown-key and bad-position cases recur. Each
// accepted transaction is run through a local model of the table and the
// result is compared field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import okrt_pkg::*;

    localparam int SLOTS      = 32;
    localparam int ITEM_GOAL  = 950;
    localparam int QUIET_TAIL = 120;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [SAL_W-1:0] sal;
        logic [DEP_W-1:0] dep;
        logic [POS_W-1:0] pos;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [KEY_W-1:0]   key;
        logic [SAL_W-1:0]   sal;
        logic [DEP_W-1:0]   dep;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [ACT_W-1:0]   action = '0;
    logic [KEY_W-1:0]   key_id = '0;
    logic [SAL_W-1:0]   salary_value = '0;
    logic [DEP_W-1:0]   department_value = '0;
    logic [POS_W-1:0]   position = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   entry_key;
    logic [SAL_W-1:0]   entry_salary;
    logic [DEP_W-1:0]   entry_department;
    logic [COUNT_W-1:0] entry_count;

    ordered_keyed_record_table DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .key_id           (key_id),
        .salary_value     (salary_value),
        .department_value (department_value),
        .position         (position),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .entry_key        (entry_key),
        .entry_salary     (entry_salary),
        .entry_department (entry_department),
        .entry_count      (entry_count)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Table model, advanced once per accepted transaction
    logic [KEY_W-1:0] slot_key [SLOTS];
    logic [SAL_W-1:0] slot_salary [SLOTS];
    logic [DEP_W-1:0] slot_dept [SLOTS];
    int               slot_total = 0;
    logic [KEY_W-1:0] key_counter = '0;

    request_t pending_requests [$];
    outcome_t pending_outcomes [$];
    int       accepted = 0;
    int       delivered = 0;
    int       mismatches = 0;
    int       status_seen [8];

    function automatic outcome_t apply_to_table(request_t r);
        outcome_t o;
        int       hit;
        o = '0;
        o.status = ST_OK;
        hit = -1;
        for (int i = 0; i < slot_total; i++)
            if (hit < 0 && slot_key[i] == r.key)
                hit = i;
        case (r.action)
            ACT_LOAD, ACT_ADD:
            begin
                if (slot_total >= SLOTS)
                    o.status = ST_FULL;
                else
                begin
                    slot_salary[slot_total] = r.sal;
                    slot_dept[slot_total] = r.dep;
                    if (r.action == ACT_LOAD)
                    begin
                        slot_key[slot_total] = r.key;
                        key_counter = KEY_W'(slot_total + 1);
                    end
                    else
                    begin
                        key_counter = key_counter + 1'b1;
                        slot_key[slot_total] = key_counter;
                        o.key = key_counter;
                    end
                    slot_total++;
                end
            end
            ACT_UPDATE:
            begin
                if (hit < 0)
                    o.status = ST_UNKNOWN;
                else
                begin
                    slot_salary[hit] = r.sal;
                    slot_dept[hit] = r.dep;
                end
            end
            ACT_DELETE:
            begin
                if (slot_total == 0)
                    o.status = ST_EMPTY;
                else if (hit < 0)
                    o.status = ST_UNKNOWN;
                else
                begin
                    for (int i = hit; i < slot_total - 1; i++)
                    begin
                        slot_key[i] = slot_key[i + 1];
                        slot_salary[i] = slot_salary[i + 1];
                        slot_dept[i] = slot_dept[i + 1];
                    end
                    slot_total--;
                end
            end
            ACT_READ:
            begin
                if (int'(r.pos) >= slot_total)
                    o.status = ST_BADPOS;
                else
                begin
                    o.key = slot_key[r.pos];
                    o.sal = slot_salary[r.pos];
                    o.dep = slot_dept[r.pos];
                end
            end
            default:
            begin
            end
        endcase
        o.count = COUNT_W'(slot_total);
        return o;
    endfunction

    // Driver
    int  send_gap = 0;
    bit  send_quiet;
    request_t next_req;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pending_outcomes.insert(pending_outcomes.size(), apply_to_table(
                    '{action, key_id, salary_value, department_value, position}));
                accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                send_quiet = pending_requests.size() < QUIET_TAIL
                             || (accepted / 64) % 3 == 2;
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!send_quiet && $urandom_range(0, 4) == 0)
                begin
                    send_gap = $urandom_range(0, 2);
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    action <= next_req.action;
                    key_id <= next_req.key;
                    salary_value <= next_req.sal;
                    department_value <= next_req.dep;
                    position <= next_req.pos;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor
    int       stall_left = 0;
    bit       recv_quiet;
    outcome_t want;

    task automatic compare_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                delivered++;
                status_seen[status]++;
                if (pending_outcomes.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("entry_key", want.key, entry_key);
                    compare_field("entry_salary", want.sal, entry_salary);
                    compare_field("entry_department", want.dep, entry_department);
                    compare_field("entry_count", want.count, entry_count);
                end
            end
            recv_quiet = pending_requests.size() < QUIET_TAIL
                         || (delivered / 64) % 3 == 1;
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!recv_quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Stimulus; plan_keys mirrors the key order so that updates and deletes
    // can target live records.
    logic [KEY_W-1:0] plan_keys [$];
    int               plan_counter = 0;
    int               planned = 0;

    task automatic queue_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                 logic [SAL_W-1:0] s, logic [DEP_W-1:0] d,
                                 logic [POS_W-1:0] p);
        int       hit;
        request_t req;
        hit = -1;
        foreach (plan_keys[i])
            if (hit < 0 && plan_keys[i] == k)
                hit = i;
        case (act)
            ACT_LOAD:
                if (plan_keys.size() < SLOTS)
                begin
                    plan_keys.insert(plan_keys.size(), k);
                    plan_counter = plan_keys.size();
                end
            ACT_ADD:
                if (plan_keys.size() < SLOTS)
                begin
                    plan_counter++;
                    plan_keys.insert(plan_keys.size(), KEY_W'(plan_counter));
                end
            ACT_DELETE:
                if (hit >= 0)
                    plan_keys.delete(hit);
            default:
            begin
            end
        endcase
        if (act <= ACT_READ)
            planned++;
        req.action = act;
        req.key    = k;
        req.sal    = s;
        req.dep    = d;
        req.pos    = p;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    function automatic logic [31:0] pick_bits(int width);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            default: v = $urandom;
        endcase
        return v & ((32'd1 << width) - 1);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int reuse_pct);
        if (plan_keys.size() > 0 && $urandom_range(0, 99) < reuse_pct)
            return plan_keys[$urandom_range(0, plan_keys.size() - 1)];
        if ($urandom_range(0, 1) == 0)
            return KEY_W'($urandom_range(0, 40));
        return KEY_W'(pick_bits(KEY_W));
    endfunction

    int               mode;
    int               roll;
    int               cut [4];
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;

    initial
    begin
        // empty table
        queue_request(ACT_DELETE, 24'h0, 24'h0, 16'h0, 5'd0);
        queue_request(ACT_UPDATE, 24'h5, 24'h1, 16'h1, 5'd0);
        queue_request(ACT_READ, 24'h0, 24'h0, 16'h0, 5'd0);
        queue_request(ACT_READ, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 5'd31);
        // extremes, duplicate keys, key counter after load
        queue_request(ACT_LOAD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 5'd31);
        queue_request(ACT_LOAD, 24'h0, 24'h0, 16'h0, 5'd0);
        queue_request(ACT_ADD, 24'h0, 24'h123456, 16'h8001, 5'd0);
        queue_request(ACT_LOAD, 24'hFFFFFF, 24'h0, 16'h0, 5'd0);
        queue_request(ACT_ADD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 5'd31);
        queue_request(ACT_UPDATE, 24'hFFFFFF, 24'h00ABCD, 16'h1234, 5'd0);
        for (int i = 0; i < 6; i++)
            queue_request(ACT_READ, 24'h0, 24'h0, 16'h0, POS_W'(i));
        queue_request(ACT_DELETE, 24'hFFFFFF, 24'h0, 16'h0, 5'd0);
        queue_request(ACT_READ, 24'h0, 24'h0, 16'h0, 5'd0);
        queue_request(ACT_READ, 24'h0, 24'h0, 16'h0, 5'd2);
        queue_request(ACT_DELETE, 24'hFFFFFF, 24'h0, 16'h0, 5'd0);
        queue_request(ACT_DELETE, 24'h777777, 24'h0, 16'h0, 5'd0);
        for (int a = 5; a < 8; a++)
            queue_request(ACT_W'(a), 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 5'd31);

        mode = 0;
        while (planned < ITEM_GOAL)
        begin
            if (planned % 48 == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0:       cut = '{33, 68, 78, 83};  // grow
                1:       cut = '{5, 15, 25, 75};   // shrink
                default: cut = '{15, 30, 50, 70};
            endcase
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 3)
                act = ACT_W'($urandom_range(5, 7));
            else if (roll < cut[0])
                act = ACT_LOAD;
            else if (roll < cut[1])
                act = ACT_ADD;
            else if (roll < cut[2])
                act = ACT_UPDATE;
            else if (roll < cut[3])
                act = ACT_DELETE;
            else
                act = ACT_READ;
            if (plan_keys.size() > 0 && $urandom_range(0, 4) != 0)
                pos = POS_W'($urandom_range(0, plan_keys.size() - 1));
            else
                pos = POS_W'($urandom_range(0, 31));
            queue_request(act, pick_key(act == ACT_LOAD ? 25 : 80),
                          SAL_W'(pick_bits(SAL_W)), DEP_W'(pick_bits(DEP_W)), pos);
        end

        @(posedge clk);
        while (pending_requests.size() != 0 || pending_outcomes.size() != 0 || in_valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $error("%0d results never arrived", pending_outcomes.size());
            mismatches++;
        end
        $display("Checked %0d transactions: %0d ok, %0d unknown key, %0d empty, %0d full,",
                 delivered, status_seen[ST_OK], status_seen[ST_UNKNOWN],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        $display("%0d bad position; %0d field mismatches.",
                 status_seen[ST_BADPOS], mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/okrt_pkg.sv
rtl/okrt_cell.sv
rtl/ordered_keyed_record_table.sv
rtl/okrt_checker.sv
test/testbench.sv
